// ----- rtl/lcdnw_pkg.sv -----
// Shared types and constants for the character LCD nibble writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcdnw_pkg;

  // operation codes on the func field
  localparam logic [2:0] FUNC_INIT    = 3'd0;
  localparam logic [2:0] FUNC_CMD     = 3'd1;
  localparam logic [2:0] FUNC_CHAR    = 3'd2;
  localparam logic [2:0] FUNC_POS     = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;
  localparam logic [2:0] FUNC_NEWLINE = 3'd5;

  // pause_before codes
  localparam logic [1:0] PAUSE_NONE    = 2'd0;
  localparam logic [1:0] PAUSE_POWERUP = 2'd1;
  localparam logic [1:0] PAUSE_PAGE    = 2'd2;

  // config register indexes
  localparam logic [7:0] REG_POWERUP = 8'd0;
  localparam logic [7:0] REG_SETTLE  = 8'd1;
  localparam logic [7:0] REG_PAGE    = 8'd2;
  localparam logic [7:0] REG_ENABLE  = 8'd3;

  // display command bytes
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h80;
  localparam logic [7:0] CMD_ROW2  = 8'hC0;
  localparam logic [7:0] POS_BASE  = 8'h80;
  localparam logic [7:0] POS_ROW2  = 8'h40;

  // transfer sequencer
  localparam int STEP_W     = 4;
  localparam int INIT_STEPS = 12;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_CHAR = 2'd2
  } kind_e;

  // one classified item, front to back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_val;
    logic       full_page;
    logic       row_change;
  } job_t;

endpackage

// ----- rtl/lcdnw_front.sv -----
// Front end: accepts items, tracks the cell count, classifies into jobs.
// Depends on lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_front import lcdnw_pkg::*; #(
  parameter int ROW_CELLS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic       row_i,
  input  logic [3:0] column_i,
  input  logic       fifo_full_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam int CountMax = (2 * ROW_CELLS > ROW_CELLS + 15) ? 2 * ROW_CELLS : ROW_CELLS + 15;
  localparam int CW = $clog2(CountMax + 1);
  localparam logic [CW-1:0] RowCnt  = CW'(ROW_CELLS);
  localparam logic [CW-1:0] PageCnt = CW'(2 * ROW_CELLS);

  logic [CW-1:0] cell_count_q, cell_count_d;
  logic          accept;
  logic          known;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign push_o     = accept && known;

  always_comb begin
    job_o.kind       = KIND_CMD;
    job_o.byte_val   = data_byte_i;
    job_o.full_page  = 1'b0;
    job_o.row_change = 1'b0;
    cell_count_d     = cell_count_q;
    known            = 1'b1;
    unique case (func_i)
      FUNC_INIT: begin
        job_o.kind   = KIND_INIT;
        cell_count_d = '0;
      end
      FUNC_CMD: begin
      end
      FUNC_CHAR: begin
        job_o.kind       = KIND_CHAR;
        job_o.full_page  = (cell_count_q >= PageCnt);
        job_o.row_change = (cell_count_q < PageCnt) && (cell_count_q == RowCnt);
        cell_count_d     = (cell_count_q >= PageCnt) ? CW'(1) : cell_count_q + CW'(1);
      end
      FUNC_POS: begin
        job_o.byte_val = POS_BASE + {4'b0000, column_i} + (row_i ? POS_ROW2 : 8'h00);
        cell_count_d   = row_i ? RowCnt + CW'(column_i) : CW'(column_i);
      end
      FUNC_CLEAR: begin
        job_o.byte_val = CMD_CLEAR;
        cell_count_d   = '0;
      end
      FUNC_NEWLINE: begin
        job_o.byte_val = CMD_ROW2;
        cell_count_d   = RowCnt;
      end
      default: begin
        // unused codes: dropped, count untouched
        known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= '0;
    end else if (accept) begin
      cell_count_q <= cell_count_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_count_q <= CW'(CountMax))
    else $error("cell count out of range");

endmodule

// ----- rtl/lcdnw_fifo.sv -----
// Short job queue between front and back ends.
// Depends on lcdnw_pkg for the job type.
`timescale 1ns / 1ps

module lcdnw_fifo import lcdnw_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

  job_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNTW'(1);
        2'b01:   count_q <= count_q - CNTW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// ----- rtl/lcdnw_back.sv -----
// Back end: steps through the transfers of the head job, one per cycle unless
// the output stalls, into the output register. Depends on lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_back import lcdnw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] transfer_word_o,
  output logic [1:0] pause_before_o,
  output logic       settle_after_o,
  output logic       last_o
);

  // nibbles of the power-up sequence: 3,3,3,2 then 0x28 0x08 0x01 0x0F
  localparam logic [3:0] InitNib [INIT_STEPS] = '{
    4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'h8, 4'h0, 4'h1, 4'h0, 4'hF
  };

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] n_steps;
  logic [STEP_W-1:0] data_start;
  logic              load;
  logic              t_last;
  logic [4:0]        t_word;
  logic [1:0]        t_pause;
  logic              t_settle;
  logic [7:0]        cmd_byte;
  logic [3:0]        cmd_nib;
  logic [3:0]        dat_nib;

  logic              out_valid_q;
  logic [4:0]        word_q;
  logic [1:0]        pause_q;
  logic              settle_q;
  logic              last_q;

  assign load = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    n_steps    = STEP_W'(2);
    data_start = '0;
    cmd_byte   = job_i.byte_val;
    t_word     = '0;
    t_pause    = PAUSE_NONE;
    t_settle   = 1'b0;
    unique case (job_i.kind)
      KIND_INIT: begin
        n_steps  = STEP_W'(INIT_STEPS);
        t_word   = {1'b0, InitNib[step_q]};
        t_pause  = (step_q == '0) ? PAUSE_POWERUP : PAUSE_NONE;
        t_settle = (step_q < STEP_W'(4)) || step_q[0];
      end
      KIND_CHAR: begin
        n_steps    = STEP_W'(2) + (job_i.full_page ? STEP_W'(4) : '0)
                     + (job_i.row_change ? STEP_W'(2) : '0);
        data_start = n_steps - STEP_W'(2);
        if (job_i.full_page) begin
          cmd_byte = step_q[1] ? CMD_HOME : CMD_CLEAR;
        end else begin
          cmd_byte = CMD_ROW2;
        end
      end
      default: begin
        n_steps = STEP_W'(2);
      end
    endcase
    cmd_nib = step_q[0] ? cmd_byte[3:0] : cmd_byte[7:4];
    dat_nib = step_q[0] ? job_i.byte_val[3:0] : job_i.byte_val[7:4];
    if (job_i.kind == KIND_CMD) begin
      t_word   = {1'b0, cmd_nib};
      t_settle = step_q[0];
    end else if (job_i.kind == KIND_CHAR) begin
      if (step_q >= data_start) begin
        t_word = {1'b1, dat_nib};
      end else begin
        t_word   = {1'b0, cmd_nib};
        t_settle = step_q[0];
        t_pause  = (job_i.full_page && step_q == '0) ? PAUSE_PAGE : PAUSE_NONE;
      end
    end
    t_last = (step_q == n_steps - STEP_W'(1));
  end

  assign pop_o  = load && t_last;
  assign step_d = t_last ? '0 : step_q + STEP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= t_word;
      pause_q  <= t_pause;
      settle_q <= t_settle;
      last_q   <= t_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign transfer_word_o = word_q;
  assign pause_before_o  = pause_q;
  assign settle_after_o  = settle_q;
  assign last_o          = last_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(INIT_STEPS))
    else $error("transfer step beyond longest sequence");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> !empty_i)
    else $error("job left the queue mid sequence");

endmodule

// ----- rtl/char_lcd_nibble_writer.sv -----
// Top level of the character LCD nibble writer: config registers, front end,
// job queue and transfer back end. Depends on lcdnw_pkg, lcdnw_front,
// lcdnw_fifo and lcdnw_back.
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | input     | in_valid_i/in_ready_o | func_i data_byte_i row_i column_i
//  out     | output    | out_valid_o/out_ready_i | transfer_word_o pause_before_o
//          |           |                       | settle_after_o last_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
//  An input word is taken whenever the job queue has room, so words may
//  arrive back to back. The back end emits one transfer per cycle from its
//  output register while out_ready_i allows: an item makes 2 transfers
//  (command, character), 4 (character with row change), 6 (character with
//  page wrap) or 12 (init); the output port sets the sustained rate. Reset
//  clears the cell count, queue and sequencer. A stall on the output fills
//  the queue, then drops in_ready_o.

module char_lcd_nibble_writer import lcdnw_pkg::*; #(
  parameter int ROW_CELLS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        row_i,
  input  logic [3:0]  column_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  transfer_word_o,
  output logic [1:0]  pause_before_o,
  output logic        settle_after_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Timing registers, written through the cfg port. No output of this block
  // carries them; pause_before and settle_after carry only wait codes.
  logic [31:0] powerup_wait_q;
  logic [31:0] cmd_settle_q;
  logic [31:0] page_hold_q;
  logic [15:0] enable_pulse_q;

  logic push;
  logic pop;
  logic fifo_full;
  logic fifo_empty;
  job_t job_in;
  job_t job_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powerup_wait_q <= 32'd600000;
      cmd_settle_q   <= 32'd125000;
      page_hold_q    <= 32'd60000000;
      enable_pulse_q <= 16'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POWERUP: powerup_wait_q <= cfg_data_i;
        REG_SETTLE:  cmd_settle_q   <= cfg_data_i;
        REG_PAGE:    page_hold_q    <= cfg_data_i;
        REG_ENABLE:  enable_pulse_q <= cfg_data_i[15:0];
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  lcdnw_front #(
    .ROW_CELLS(ROW_CELLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  lcdnw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .job_o   (job_head)
  );

  lcdnw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (fifo_empty),
    .job_i           (job_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .transfer_word_o (transfer_word_o),
    .pause_before_o  (pause_before_o),
    .settle_after_o  (settle_after_o),
    .last_o          (last_o)
  );

endmodule

// ----- verif/char_lcd_nibble_writer_test.sv -----
// Self-checking bench for char_lcd_nibble_writer: random and directed LCD operations are
// predicted into nibble transfers and compared word by word at the output port.
// Depends on lcdnw_pkg and the char_lcd_nibble_writer RTL only.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_test;
  import lcdnw_pkg::*;

  localparam int ROW_CELLS      = 16;
  localparam int SETTLE_CYCLES  = 48;    // drain time after the last expected word
  localparam int QUIET_LIMIT    = 4000;  // cycles with no handshake at all
  localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off, fills the job queue
  localparam int RX_HOLD_AT     = 300;   // transfer count that triggers the hold-off
  localparam int IDLE_PCT       = 11;

  // unmapped config register index
  localparam logic [7:0] REG_NONE      = 8'hFF;

  // display commands and init nibbles not in the package
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0F;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [4:0] RS_DATA      = 5'h10;

  typedef struct {
    logic [2:0] func;
    logic [7:0] data;
    logic       row;
    logic [3:0] col;
  } lcd_op_t;

  typedef struct {
    logic [4:0] word;
    logic [1:0] pause;
    logic       settle;
    logic       last;
  } xfer_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i      = '0;
  logic [7:0]  data_byte_i = '0;
  logic        row_i       = 1'b0;
  logic [3:0]  column_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  transfer_word_o;
  logic [1:0]  pause_before_o;
  logic        settle_after_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  lcd_op_t op_backlog[$];     // operations waiting for the driver
  xfer_t   xfer_expected[$];  // predicted transfers, oldest first
  logic [5:0] lcd_cells = '0; // predicted cursor cell count
  int fail_count = 0;
  int ops_taken  = 0;         // written by the driver only
  int xfers_seen = 0;         // written by the monitor only

  char_lcd_nibble_writer #(.ROW_CELLS(ROW_CELLS)) dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Transfer predictor. Config registers drive no output of the block, so the
  // expected stream depends on the operation and cell count.
  // ---------------------------------------------------------------------------
  function automatic void queue_nibble(logic [4:0] word, logic [1:0] pause, logic settle);
    xfer_t x;
    x.word   = word;
    x.pause  = pause;
    x.settle = settle;
    x.last   = 1'b0;
    xfer_expected.push_back(x);
  endfunction

  // command byte: high nibble, then low nibble with settle wait
  function automatic void queue_cmd(logic [7:0] cmd, logic [1:0] pause);
    queue_nibble({1'b0, cmd[7:4]}, pause, 1'b0);
    queue_nibble({1'b0, cmd[3:0]}, PAUSE_NONE, 1'b1);
  endfunction

  function automatic void predict_transfers(lcd_op_t op);
    int n_before;
    n_before = xfer_expected.size();
    case (op.func)
      FUNC_INIT: begin
        queue_nibble({1'b0, NIB_WAKE}, PAUSE_POWERUP, 1'b1);
        queue_nibble({1'b0, NIB_WAKE}, PAUSE_NONE, 1'b1);
        queue_nibble({1'b0, NIB_WAKE}, PAUSE_NONE, 1'b1);
        queue_nibble({1'b0, NIB_4BIT}, PAUSE_NONE, 1'b1);
        queue_cmd(CMD_FUNC_SET, PAUSE_NONE);
        queue_cmd(CMD_DISP_OFF, PAUSE_NONE);
        queue_cmd(CMD_CLEAR, PAUSE_NONE);
        queue_cmd(CMD_DISP_ON, PAUSE_NONE);
        lcd_cells = '0;
      end
      FUNC_CMD: queue_cmd(op.data, PAUSE_NONE);
      FUNC_CHAR: begin
        // full screen: hold the page, clear and home first
        if (lcd_cells >= 6'(2 * ROW_CELLS)) begin
          queue_cmd(CMD_CLEAR, PAUSE_PAGE);
          queue_cmd(CMD_HOME, PAUSE_NONE);
          lcd_cells = '0;
        end
        // end of the top row: jump to row two
        if (lcd_cells == 6'(ROW_CELLS))
          queue_cmd(CMD_ROW2, PAUSE_NONE);
        queue_nibble(RS_DATA | {1'b0, op.data[7:4]}, PAUSE_NONE, 1'b0);
        queue_nibble(RS_DATA | {1'b0, op.data[3:0]}, PAUSE_NONE, 1'b0);
        lcd_cells = lcd_cells + 6'd1;
      end
      FUNC_POS: begin
        queue_cmd(POS_BASE + {4'd0, op.col} + (op.row ? POS_ROW2 : 8'd0), PAUSE_NONE);
        lcd_cells = (op.row ? 6'(ROW_CELLS) : 6'd0) + {2'd0, op.col};
      end
      FUNC_CLEAR: begin
        queue_cmd(CMD_CLEAR, PAUSE_NONE);
        lcd_cells = '0;
      end
      FUNC_NEWLINE: begin
        queue_cmd(CMD_ROW2, PAUSE_NONE);
        lcd_cells = 6'(ROW_CELLS);
      end
      default: ;  // unused codes: no transfers, state kept
    endcase
    if (xfer_expected.size() > n_before)
      xfer_expected[xfer_expected.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops the backlog, holds a word until accepted, predicts on accept.
  // Idles at random except for a calm stretch of accepted ops.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    lcd_op_t op;
    lcd_op_t taken;
    logic    calm;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken.func = func_i;
        taken.data = data_byte_i;
        taken.row  = row_i;
        taken.col  = column_i;
        predict_transfers(taken);
        ops_taken++;
      end
      // slot is free once nothing is offered or the offer was just taken
      if (!in_valid_i || in_ready_o) begin
        calm = (ops_taken >= 120 && ops_taken < 220);
        if (op_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          op = op_backlog.pop_front();
          func_i      <= op.func;
          data_byte_i <= op.data;
          row_i       <= op.row;
          column_i    <= op.col;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted transfer against the oldest prediction and
  // drives out_ready_i. One long hold-off lets the job queue fill and stall
  // the input side.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    xfer_t x;
    logic  calm;
    int    hold_left;
    logic  held_once;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      held_once = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (xfer_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer word %0h", transfer_word_o));
        end else begin
          x = xfer_expected.pop_front();
          if (transfer_word_o !== x.word)
            report_mismatch($sformatf("transfer %0d word %0h, want %0h",
                                      xfers_seen, transfer_word_o, x.word));
          if (pause_before_o !== x.pause)
            report_mismatch($sformatf("transfer %0d pause %0d, want %0d",
                                      xfers_seen, pause_before_o, x.pause));
          if (settle_after_o !== x.settle)
            report_mismatch($sformatf("transfer %0d settle %0b, want %0b",
                                      xfers_seen, settle_after_o, x.settle));
          if (last_o !== x.last)
            report_mismatch($sformatf("transfer %0d last %0b, want %0b",
                                      xfers_seen, last_o, x.last));
        end
        xfers_seen++;
      end
      if (!held_once && xfers_seen >= RX_HOLD_AT) begin
        held_once = 1'b1;
        hold_left = RX_HOLD_CYCLES;
      end
      calm = (xfers_seen >= 500 && xfers_seen < 800);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any handshake resets the quiet counter.
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d transfers pending",
                 quiet, xfer_expected.size());
        $display("char_lcd_nibble_writer_test: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and phase control
  // ---------------------------------------------------------------------------
  function automatic lcd_op_t make_op(logic [2:0] func, logic [7:0] data,
                                      logic row, logic [3:0] col);
    lcd_op_t op;
    op.func = func;
    op.data = data;
    op.row  = row;
    op.col  = col;
    return op;
  endfunction

  function automatic lcd_op_t rand_op(logic [2:0] func);
    return make_op(func, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   4'($urandom_range(15)));
  endfunction

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_registers(logic [31:0] powerup, logic [31:0] settle,
                                logic [31:0] hold, logic [31:0] pulse,
                                logic [7:0] junk_idx);
    cfg_write(REG_POWERUP, powerup);
    cfg_write(REG_SETTLE, settle);
    cfg_write(REG_PAGE, hold);
    cfg_write(REG_ENABLE, pulse);
    // write to an unmapped index must be dropped
    cfg_write(junk_idx, ~pulse);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every offered op has been taken and every transfer checked,
  // then give the block time to drop anything that makes no transfer
  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_valid_i || xfer_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed text with runs of characters long enough to wrap the
  // page; unused codes are mixed in but do not count
  task automatic random_batch(int n);
    int counted;
    int run;
    int pick;
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(99) < 8) begin
        run = $urandom_range(8, 40);
        repeat (run) op_backlog.push_back(rand_op(FUNC_CHAR));
        counted += run;
      end else begin
        pick = $urandom_range(99);
        if (pick < 45)      op_backlog.push_back(rand_op(FUNC_CHAR));
        else if (pick < 60) op_backlog.push_back(rand_op(FUNC_CMD));
        else if (pick < 72) op_backlog.push_back(rand_op(FUNC_POS));
        else if (pick < 80) op_backlog.push_back(rand_op(FUNC_NEWLINE));
        else if (pick < 86) op_backlog.push_back(rand_op(FUNC_CLEAR));
        else if (pick < 90) op_backlog.push_back(rand_op(FUNC_INIT));
        else                op_backlog.push_back(rand_op(3'($urandom_range(6, 7))));
        if (pick < 90) counted++;
      end
    end
  endtask

  initial begin : sequencer
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // low extremes, shortest enable pulse
    load_registers(32'd0, 32'd0, 32'd0, 32'd1, 8'd4);

    // directed: init, field extremes, every op, row change, page wrap,
    // newline into row change, unused codes
    op_backlog.push_back(make_op(FUNC_INIT, 8'h00, 1'b0, 4'd0));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h00, 1'b0, 4'd0));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'hFF, 1'b1, 4'd15));
    op_backlog.push_back(make_op(FUNC_CMD, 8'h00, 1'b0, 4'd0));
    op_backlog.push_back(make_op(FUNC_CMD, 8'hFF, 1'b1, 4'd15));
    op_backlog.push_back(make_op(FUNC_POS, 8'h00, 1'b0, 4'd0));
    op_backlog.push_back(make_op(FUNC_POS, 8'hFF, 1'b0, 4'd15));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h41, 1'b0, 4'd0));   // fills top row
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h42, 1'b0, 4'd0));   // row change
    op_backlog.push_back(make_op(FUNC_POS, 8'h00, 1'b1, 4'd15));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h5A, 1'b0, 4'd0));   // last cell
    op_backlog.push_back(make_op(FUNC_CHAR, 8'hA5, 1'b1, 4'd7));   // page wrap
    op_backlog.push_back(make_op(FUNC_POS, 8'h00, 1'b1, 4'd0));
    op_backlog.push_back(make_op(FUNC_NEWLINE, 8'hFF, 1'b1, 4'd15));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h3C, 1'b0, 4'd0));   // row change again
    op_backlog.push_back(make_op(FUNC_CLEAR, 8'hFF, 1'b1, 4'd15));
    op_backlog.push_back(make_op(3'd6, 8'hFF, 1'b1, 4'd15));
    op_backlog.push_back(make_op(3'd7, 8'h00, 1'b0, 4'd0));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h7E, 1'b0, 4'd0));
    op_backlog.push_back(make_op(FUNC_INIT, 8'hFF, 1'b1, 4'd15));
    op_backlog.push_back(make_op(FUNC_CHAR, 8'h81, 1'b1, 4'd9));
    wait_drained();

    // high extremes
    load_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, REG_NONE);
    random_batch(150);
    wait_drained();

    // power-on values
    load_registers(32'd600000, 32'd125000, 32'd60000000, 32'd30, 8'h80);
    random_batch(150);
    wait_drained();

    // random timing, random unmapped index
    load_registers($urandom, $urandom, $urandom, 32'($urandom_range(1, 65535)),
                   8'($urandom_range(4, 255)));
    random_batch(150);
    wait_drained();

    if (fail_count == 0) begin
      $display("char_lcd_nibble_writer_test: PASS");
    end else begin
      $display("char_lcd_nibble_writer_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lcdnw_pkg.sv
rtl/lcdnw_front.sv
rtl/lcdnw_fifo.sv
rtl/lcdnw_back.sv
rtl/char_lcd_nibble_writer.sv
verif/char_lcd_nibble_writer_test.sv
